>>> rtl/core/swvp_pkg.sv
// ----------------------------------------------------------------------------
// Stack with value purge: shared package
// Widths, operation and status codes, FSM states and the per-cell control
// bundle shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
package swvp_pkg;

   localparam int DATA_W          = 32;
   localparam int OP_W            = 2;
   localparam int STATUS_W        = 2;
   localparam int COUNT_OUT_W     = 5;
   localparam int STACK_DEPTH_DEF = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Control FSM
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic              shift_up;    // push: every entry moves one cell deeper
      logic              shift_down;  // pop: every entry moves one cell toward top
      logic              purge_en;    // scan: cells at or past first match close gap
      logic [DATA_W-1:0] key;         // value being purged
   } cell_ctrl_type;

endpackage

>>> rtl/core/stack_with_value_purge_unit.sv
// ----------------------------------------------------------------------------
// Stack with value purge: top level
// Bounded LIFO of signed words with push, pop and purge-by-value, built as
// a chain of storage cells with the top of stack in cell 0.
// ----------------------------------------------------------------------------
// Push, pop and unused op codes take effect as the item is accepted: their
// result is registered on the same edge. A purge accepts and latches the
// value, then scans the stack and removes the matching entries; a scan
// cycle that finds no further match registers the result once the result
// register is empty or being taken. Each scan cycle removes the match
// nearest the top; a one-bit match chain running through the cells picks
// it, and every cell behind it takes its neighbor's entry. One item is
// handled at a time; a new item is accepted once the result register is
// empty or being taken.
// ----------------------------------------------------------------------------
module stack_with_value_purge_unit #(
   parameter int StackDepth = swvp_pkg::STACK_DEPTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [swvp_pkg::OP_W-1:0]                 req_op,
   input  logic signed [swvp_pkg::DATA_W-1:0]        req_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [swvp_pkg::DATA_W-1:0]        rsp_popped_value,
   output logic [swvp_pkg::STATUS_W-1:0]             rsp_status,
   output logic [swvp_pkg::COUNT_OUT_W-1:0]          rsp_entry_count,
   output logic                                      rsp_is_empty,
   output logic [swvp_pkg::COUNT_OUT_W-1:0]          rsp_removed_count
);

   localparam int              CountW = $clog2(StackDepth + 1);
   localparam logic [CountW-1:0] DepthC = CountW'(StackDepth);
   localparam logic [CountW-1:0] OneC   = CountW'(1);

   swvp_pkg::state_type           state_ff, state_in;
   logic [CountW-1:0]             count_ff, count_in;
   logic [CountW-1:0]             removed_ff, removed_in;
   logic [swvp_pkg::DATA_W-1:0]   key_ff, key_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [swvp_pkg::DATA_W-1:0]            popped_ff, popped_in;
   logic [swvp_pkg::STATUS_W-1:0]          status_ff, status_in;
   logic [CountW-1:0]                      rsp_count_ff, rsp_count_in;
   logic                                   empty_ff, empty_in;
   logic [CountW-1:0]                      rsp_removed_ff, rsp_removed_in;

   swvp_pkg::cell_ctrl_type       ctrl;
   logic [swvp_pkg::DATA_W-1:0]   cell_data [StackDepth];
   logic [StackDepth:0]           match_chain;
   logic                          out_free;
   logic                          accept;
   logic                          any_match;

   // Handshake
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == swvp_pkg::ST_IDLE) & out_free;
   assign accept    = req_valid & req_ready;
   assign any_match = match_chain[StackDepth];

   // Cell commands
   always_comb begin
      ctrl.shift_up   = accept & (req_op == swvp_pkg::OP_PUSH) & (count_ff != DepthC);
      ctrl.shift_down = accept & (req_op == swvp_pkg::OP_POP) & (count_ff != '0);
      ctrl.purge_en   = (state_ff == swvp_pkg::ST_SCAN);
      ctrl.key        = key_ff;
   end

   // Cell chain
   assign match_chain[0] = 1'b0;

   for (genvar i = 0; i < StackDepth; i++) begin : g_cell
      logic [swvp_pkg::DATA_W-1:0] lower_data;
      logic [swvp_pkg::DATA_W-1:0] upper_data;

      if (i == 0) begin : g_top
         assign lower_data = req_value;
      end else begin : g_mid
         assign lower_data = cell_data[i-1];
      end

      if (i == StackDepth - 1) begin : g_bottom
         assign upper_data = '0;
      end else begin : g_inner
         assign upper_data = cell_data[i+1];
      end

      swvp_cell #(
         .Index  (i),
         .CountW (CountW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .match_in   (match_chain[i]),
         .match_out  (match_chain[i+1]),
         .data       (cell_data[i])
      );
   end

   // Control and result
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      removed_in     = removed_ff;
      key_in         = key_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      popped_in      = popped_ff;
      status_in      = status_ff;
      rsp_count_in   = rsp_count_ff;
      empty_in       = empty_ff;
      rsp_removed_in = rsp_removed_ff;

      case (state_ff)
         swvp_pkg::ST_IDLE: begin
            if (accept) begin
               popped_in      = '0;
               status_in      = swvp_pkg::STATUS_OK;
               rsp_removed_in = '0;
               rsp_valid_in   = 1'b1;
               case (req_op)
                  swvp_pkg::OP_PUSH: begin
                     if (count_ff == DepthC) begin
                        status_in = swvp_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + OneC;
                     end
                  end
                  swvp_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = swvp_pkg::STATUS_EMPTY;
                     end else begin
                        count_in  = count_ff - OneC;
                        popped_in = cell_data[0];
                     end
                  end
                  swvp_pkg::OP_PURGE: begin
                     rsp_valid_in = 1'b0;
                     key_in       = req_value;
                     removed_in   = '0;
                     state_in     = swvp_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
               empty_in     = (count_in == '0);
            end
         end
         swvp_pkg::ST_SCAN: begin
            if (any_match) begin
               count_in   = count_ff - OneC;
               removed_in = removed_ff + OneC;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               popped_in      = '0;
               status_in      = swvp_pkg::STATUS_OK;
               rsp_count_in   = count_ff;
               empty_in       = (count_ff == '0);
               rsp_removed_in = removed_ff;
               state_in       = swvp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swvp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swvp_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      removed_ff     <= removed_in;
      key_ff         <= key_in;
      popped_ff      <= popped_in;
      status_ff      <= status_in;
      rsp_count_ff   <= rsp_count_in;
      empty_ff       <= empty_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   // Drive result port
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_value  = $signed(popped_ff);
   assign rsp_status        = status_ff;
   assign rsp_entry_count   = swvp_pkg::COUNT_OUT_W'(rsp_count_ff);
   assign rsp_is_empty      = empty_ff;
   assign rsp_removed_count = swvp_pkg::COUNT_OUT_W'(rsp_removed_ff);

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC)
      else $error("entry count exceeds stack depth");

   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swvp_pkg::ST_SCAN) && any_match |=> count_ff == $past(count_ff) - OneC)
      else $error("purge step did not drop one entry");

   a_scan_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swvp_pkg::ST_SCAN) |-> !req_ready)
      else $error("input taken during purge scan");

   a_empty_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == swvp_pkg::STATUS_EMPTY) |-> popped_ff == '0)
      else $error("pop on empty stack returned data");

   a_purge_done_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && $past(state_ff == swvp_pkg::ST_SCAN) |-> rsp_count_ff == count_ff)
      else $error("purge result count mismatch");
`endif

endmodule

>>> rtl/core/swvp_cell.sv
// ----------------------------------------------------------------------------
// Stack with value purge: storage cell
// Holds one stack entry. Cell 0 is the top of the stack. Takes its lower
// neighbor's entry on push and its upper neighbor's entry on pop or when a
// purge match lies at or above it in the chain.
// ----------------------------------------------------------------------------
module swvp_cell #(
   parameter int Index  = 0,
   parameter int CountW = 5
) (
   input  logic                          clock,
   input  swvp_pkg::cell_ctrl_type       ctrl,
   input  logic [CountW-1:0]             count,
   input  logic [swvp_pkg::DATA_W-1:0]   lower_data,
   input  logic [swvp_pkg::DATA_W-1:0]   upper_data,
   input  logic                          match_in,
   output logic                          match_out,
   output logic [swvp_pkg::DATA_W-1:0]   data
);

   localparam logic [CountW-1:0] IndexC = CountW'(Index);

   logic [swvp_pkg::DATA_W-1:0] data_ff;
   logic [swvp_pkg::DATA_W-1:0] data_in;
   logic                        occupied;

   // Detect a purge match here or nearer the top
   always_comb begin
      occupied  = (IndexC < count);
      match_out = match_in | (occupied & (data_ff == ctrl.key));
   end

   // Select next entry from neighbors
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         data_in = lower_data;
      end else if (ctrl.shift_down | (ctrl.purge_en & match_out)) begin
         data_in = upper_data;
      end
   end

   // Hold entry
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> tb/sv/tb_stack_with_value_purge_unit.sv
// ----------------------------------------------------------------------------
// Stack with value purge: self-checking testbench
// Drives push, pop, purge and unused op codes into the stack and keeps its
// own model of the stack contents. Each request transfer predicts one
// response, and each response transfer is checked against the oldest
// prediction. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_stack_with_value_purge_unit;

   localparam int                        DEPTH       = swvp_pkg::STACK_DEPTH_DEF;
   localparam logic [swvp_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int                        MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [swvp_pkg::DATA_W-1:0]   popped;
      logic [swvp_pkg::STATUS_W-1:0]        status;
      logic [swvp_pkg::COUNT_OUT_W-1:0]     count;
      logic                                 empty;
      logic [swvp_pkg::COUNT_OUT_W-1:0]     removed;
   } stack_result_type;

   logic                                     clock;
   logic                                     reset;
   logic                                     req_valid;
   logic                                     req_ready;
   logic [swvp_pkg::OP_W-1:0]                req_op;
   logic signed [swvp_pkg::DATA_W-1:0]       req_value;
   logic                                     rsp_valid;
   logic                                     rsp_ready;
   logic signed [swvp_pkg::DATA_W-1:0]       rsp_popped_value;
   logic [swvp_pkg::STATUS_W-1:0]            rsp_status;
   logic [swvp_pkg::COUNT_OUT_W-1:0]         rsp_entry_count;
   logic                                     rsp_is_empty;
   logic [swvp_pkg::COUNT_OUT_W-1:0]         rsp_removed_count;

   // Model of the stack: slot 0 is the bottom
   logic signed [swvp_pkg::DATA_W-1:0]       model_words [DEPTH];
   int                                       model_fill;

   stack_result_type                         pending_results [$];
   int                                       error_count = 0;
   int                                       send_idle_pct;
   int                                       recv_stall_pct;

   stack_with_value_purge_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_removed_count (rsp_removed_count)
   );

   always #6 clock = ~clock;

   // Apply one operation to the model and return the response it gives
   function automatic stack_result_type apply_stack_op(
         input logic [swvp_pkg::OP_W-1:0]          op,
         input logic signed [swvp_pkg::DATA_W-1:0] value);
      stack_result_type res;
      int               kept;
      int               dropped;
      res.popped = '0;
      res.status = swvp_pkg::STATUS_OK;
      dropped    = 0;
      case (op)
         swvp_pkg::OP_PUSH: begin
            if (model_fill >= DEPTH) begin
               res.status = swvp_pkg::STATUS_FULL;
            end else begin
               model_words[model_fill] = value;
               model_fill++;
            end
         end
         swvp_pkg::OP_POP: begin
            if (model_fill == 0) begin
               res.status = swvp_pkg::STATUS_EMPTY;
            end else begin
               model_fill--;
               res.popped = model_words[model_fill];
            end
         end
         swvp_pkg::OP_PURGE: begin
            // Compact the survivors toward the bottom, keeping their order
            kept = 0;
            for (int i = 0; i < model_fill; i++) begin
               if (model_words[i] == value) begin
                  dropped++;
               end else begin
                  model_words[kept] = model_words[i];
                  kept++;
               end
            end
            model_fill = kept;
         end
         default: begin
         end
      endcase
      res.count   = model_fill[swvp_pkg::COUNT_OUT_W-1:0];
      res.empty   = (model_fill == 0);
      res.removed = dropped[swvp_pkg::COUNT_OUT_W-1:0];
      return res;
   endfunction

   // Pick a word: mostly from a small pool so purges find matches
   function automatic logic signed [swvp_pkg::DATA_W-1:0] pick_word();
      logic signed [swvp_pkg::DATA_W-1:0] w;
      case ($urandom_range(9))
         0:       w = 32'sd0;
         1:       w = -32'sd1;
         2:       w = 32'sd7;
         3:       w = 32'sh7FFF_FFFF;
         4:       w = 32'sh8000_0000;
         5, 6:    w = $urandom_range(3);
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // Send one request; entered and left at a falling edge
   task automatic send_item(input logic [swvp_pkg::OP_W-1:0]          op,
                            input logic signed [swvp_pkg::DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_results.push_back(apply_stack_op(op, value));
      @(negedge clock);
   endtask

   // Pop on empty, field extremes, unused op code, purge of an absent word
   task automatic test_empty_and_extremes();
      send_item(swvp_pkg::OP_POP, 32'sd0);
      send_item(swvp_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      send_item(swvp_pkg::OP_PUSH, 32'sh8000_0000);
      send_item(swvp_pkg::OP_PUSH, 32'sd0);
      send_item(swvp_pkg::OP_PUSH, -32'sd1);
      send_item(OP_UNUSED, 32'sh5A5A_A5A5);
      send_item(swvp_pkg::OP_PURGE, 32'sd12345);
   endtask

   // Fill to capacity with repeated words, then push on a full stack
   task automatic test_fill_and_overflow();
      for (int i = 0; i < DEPTH - 4; i++) begin
         send_item(swvp_pkg::OP_PUSH, (i % 2 == 0) ? 32'sd7 : 32'(i));
      end
      send_item(swvp_pkg::OP_PUSH, 32'sd99);
   endtask

   // Purge many matches in one request and check the order of survivors
   task automatic test_purge_order();
      send_item(swvp_pkg::OP_PURGE, 32'sd7);
      send_item(swvp_pkg::OP_POP, 32'sd0);
      send_item(swvp_pkg::OP_PURGE, 32'sh8000_0000);
      send_item(swvp_pkg::OP_POP, -32'sd1);
      send_item(swvp_pkg::OP_POP, 32'sd0);
   endtask

   // Random traffic in blocks that lean toward filling or draining
   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      int                         push_pct;
      int                         purge_pct;
      int                         r;
      logic [swvp_pkg::OP_W-1:0]  op;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      push_pct       = 60;
      purge_pct      = 10;
      for (int n = 0; n < n_items; n++) begin
         if (n % 32 == 0) begin
            if ($urandom_range(1) == 1) begin
               push_pct  = 60;
               purge_pct = 10;
            end else begin
               push_pct  = 25;
               purge_pct = 25;
            end
         end
         r = $urandom_range(99);
         if (r < 5)                              op = OP_UNUSED;
         else if (r < 5 + push_pct)              op = swvp_pkg::OP_PUSH;
         else if (r < 5 + push_pct + purge_pct)  op = swvp_pkg::OP_PURGE;
         else                                    op = swvp_pkg::OP_POP;
         send_item(op, pick_word());
      end
   endtask

   // Drive the receiver stall on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check each response transfer against the oldest prediction
   always @(posedge clock) begin
      stack_result_type got;
      stack_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_popped_value, rsp_status, rsp_entry_count, rsp_is_empty,
                 rsp_removed_count};
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected response: popped=%0d status=%0d count=%0d %s%0b %s%0d",
                        got.popped, got.status, got.count, "empty=", got.empty,
                        "removed=", got.removed);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("mismatch: expected popped=%0d status=%0d count=%0d %s%0b %s%0d",
                           want.popped, want.status, want.count, "empty=", want.empty,
                           "removed=", want.removed);
                  $display("          actual   popped=%0d status=%0d count=%0d %s%0b %s%0d",
                           got.popped, got.status, got.count, "empty=", got.empty,
                           "removed=", got.removed);
               end
            end
         end
      end
   end

   // Bound the run
   initial begin
      #(12 * 2_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = swvp_pkg::OP_PUSH;
      req_value      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      model_fill     = 0;
      for (int i = 0; i < DEPTH; i++) model_words[i] = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_and_extremes();
      test_fill_and_overflow();
      test_purge_order();
      test_random_traffic(306, 0, 0);
      test_random_traffic(306, 81, 0);
      test_random_traffic(306, 0, 81);
      test_random_traffic(306, 27, 27);

      // Drain outstanding responses, then watch for strays
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> stack_with_value_purge_unit.f
rtl/core/swvp_pkg.sv
rtl/core/swvp_cell.sv
rtl/core/stack_with_value_purge_unit.sv
tb/sv/tb_stack_with_value_purge_unit.sv
